// ----- src/fqs_pkg.sv -----
// fqs_pkg: shared types and codes for the fifo queue with search
// used by fqs_ctrl, fqs_datapath and fifo_queue_with_search_core
package fqs_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  typedef enum logic [1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_MATCH    = 3'd4,
    ST_NOMATCH  = 3'd5,
    ST_LISTED   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_WALK,
    FSM_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;         // latch the incoming request
    logic    emit;         // load a single result with emit_status
    status_t emit_status;
    logic    push;         // write value at the rear
    logic    start;        // clear walk counters
    logic    walk;         // step through the entries
    logic    pop;          // drop the front entry
    logic    finish;       // close a search run
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic out_free;
    logic walk_done;
  } dp_stat_t;

endpackage

// ----- src/fqs_ctrl.sv -----
// fqs_ctrl: request sequencing state machine
// depends on fqs_pkg; drives fqs_datapath through ctrl_cmd_t
module fqs_ctrl
  import fqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      FSM_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        if (stat.cmd == CMD_ENQ) begin
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.full) begin
              cmd.emit_status = ST_FULL;
            end else begin
              cmd.push        = 1'b1;
              cmd.emit_status = ST_INSERTED;
            end
            state_next = FSM_IDLE;
          end
        end else if (stat.empty) begin
          if (stat.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_EMPTY;
            state_next      = FSM_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          state_next = FSM_WALK;
        end
      end
      FSM_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          if (stat.cmd == CMD_DEQ) begin
            cmd.pop    = 1'b1;
            state_next = FSM_IDLE;
          end else if (stat.cmd == CMD_SEARCH) begin
            state_next = FSM_FINISH;
          end else begin
            state_next = FSM_IDLE;
          end
        end
      end
      FSM_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

endmodule

// ----- src/fqs_datapath.sv -----
// fqs_datapath: entry ring memory, pointers, walk stage and result register
// depends on fqs_pkg; steered by fqs_ctrl
module fqs_datapath
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [VALUE_W-1:0]  s_tdata,
  input  logic [1:0]          s_tuser,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [39:0]         m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                 input logic [OCC_W-1:0] ofs);
    logic [OCC_W:0] sum;
    sum = (OCC_W+1)'(base) + (OCC_W+1)'(ofs);
    if (sum >= (OCC_W+1)'(DEPTH)) begin
      sum = sum - (OCC_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]   head;
  logic [OCC_W-1:0]   occ;
  cmd_t               cmd_r;
  logic [VALUE_W-1:0] val_r;

  // walk stage
  logic [OCC_W-1:0]   idx;
  logic               p_valid;
  logic [VALUE_W-1:0] p_data;
  logic [PTR_W-1:0]   p_pos;
  logic               hold_valid;
  logic [PTR_W-1:0]   hold_pos;

  logic [OCC_W-1:0]   walk_len;
  logic               p_match;
  logic               needs_out;
  logic               p_move;
  logic               issue;
  logic               out_free;

  logic               out_load;
  status_t            out_status_next;
  logic [VALUE_W-1:0] out_value_next;
  logic [POS_W-1:0]   out_pos_next;
  logic               out_last_next;

  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]   out_pos;

  assign walk_len  = (cmd_r == CMD_DEQ) ? OCC_W'(1) : occ;
  assign out_free  = !m_tvalid || m_tready;
  assign p_match   = (p_data == val_r);
  // a search match is held back until the next one shows whether it is last
  assign needs_out = p_valid && ((cmd_r != CMD_SEARCH) || (p_match && hold_valid));
  assign p_move    = cmd.walk && (!needs_out || out_free);
  assign issue     = p_move && (idx < walk_len);

  assign stat.cmd       = cmd_r;
  assign stat.empty     = (occ == '0);
  assign stat.full      = (occ == OCC_W'(DEPTH));
  assign stat.out_free  = out_free;
  assign stat.walk_done = (idx == walk_len) && !p_valid;

  // request latch and queue pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(s_tuser);
      val_r <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.push) begin
      occ <= occ + OCC_W'(1);
    end else if (cmd.pop) begin
      head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      occ  <= occ - OCC_W'(1);
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[ring_slot(head, occ)] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_data <= mem[ring_slot(head, idx)];
      p_pos  <= idx[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      p_valid    <= 1'b0;
      hold_valid <= 1'b0;
    end else if (cmd.start) begin
      idx        <= '0;
      p_valid    <= 1'b0;
      hold_valid <= 1'b0;
    end else if (p_move) begin
      p_valid <= issue;
      if (issue) begin
        idx <= idx + OCC_W'(1);
      end
      if (p_valid && (cmd_r == CMD_SEARCH) && p_match) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_move && p_valid && (cmd_r == CMD_SEARCH) && p_match) begin
      hold_pos <= p_pos;
    end
  end

  // result selection
  always_comb begin
    out_load        = 1'b0;
    out_status_next = ST_INSERTED;
    out_value_next  = '0;
    out_pos_next    = '0;
    out_last_next   = 1'b1;
    if (cmd.emit) begin
      out_load        = 1'b1;
      out_status_next = cmd.emit_status;
    end else if (cmd.finish) begin
      out_load = 1'b1;
      if (hold_valid) begin
        out_status_next = ST_MATCH;
        out_value_next  = val_r;
        out_pos_next    = POS_W'(hold_pos);
      end else begin
        out_status_next = ST_NOMATCH;
      end
    end else if (p_move && needs_out) begin
      out_load = 1'b1;
      case (cmd_r)
        CMD_DEQ: begin
          out_status_next = ST_REMOVED;
          out_value_next  = p_data;
        end
        CMD_SEARCH: begin
          out_status_next = ST_MATCH;
          out_value_next  = val_r;
          out_pos_next    = POS_W'(hold_pos);
          out_last_next   = 1'b0;
        end
        CMD_DUMP: begin
          out_status_next = ST_LISTED;
          out_value_next  = p_data;
          out_pos_next    = POS_W'(p_pos);
          out_last_next   = ((OCC_W'(p_pos) + OCC_W'(1)) == occ);
        end
        default: begin
          out_status_next = ST_INSERTED;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser   <= out_status_next;
      out_value <= out_value_next;
      out_pos   <= out_pos_next;
      m_tlast   <= out_last_next;
    end
  end

  assign m_tdata = {2'b00, out_pos, out_value};

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("write into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.empty)
    else $error("removal from an empty queue");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> (idx <= walk_len))
    else $error("walk index past the run length");
`endif

endmodule

// ----- src/fifo_queue_with_search_core.sv -----
// fifo_queue_with_search_core: top level of the bounded queue with search
// depends on fqs_pkg, fqs_ctrl and fqs_datapath
//
// a bounded first-in first-out queue of DEPTH signed 32-bit entries kept in a
// ring memory. each request carries a command in s_tuser and a value in
// s_tdata: enqueue gives one inserted or full result, dequeue one removed or
// empty result, search one match result per equal entry (front first, with
// its position) or a single no-match / empty result, and dump one listed
// result per entry or a single empty result. m_tlast marks the final result
// of a request. one request is handled at a time; the walk is set by the single
// read port of the entry memory, which streams one entry per cycle unless a
// result has to wait for the output register. a stalled m_tready holds the
// walk where it is; the next request is taken once the last result has been
// loaded into the output register, while that result may still wait.
module fifo_queue_with_search_core
  import fqs_pkg::*;
#(
  parameter int DEPTH = 16   // 2 to 64 entries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // item_value, position, zero fill
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast
);

  // command and status bundles between controller and datapath
  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  // sequencing of each request
  fqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // ring memory, pointers, walk stage and result register
  fqs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (ctrl_cmd),
    .stat     (dp_stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- verif/testbench.sv -----
// testbench: self-checking bench for fifo_queue_with_search_core
// depends on fqs_pkg for the command and status codes
`timescale 1ns / 1ps

module testbench;
  import fqs_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int SHOW_LIMIT  = 10;
  localparam int TAIL_CYCLES = 40;          // a full walk plus pipeline slack
  localparam int RAND_PER_PHASE = 36;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] item_value;
    logic [5:0]  position;
    logic        last;
  } result_t;

  // dut ports, inputs known from time zero
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;      // value
  logic [1:0]  s_tuser  = CMD_ENQ; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;            // item_value, position, zero fill
  logic [2:0]  m_tuser;            // status
  logic        m_tlast;

  // shadow of the queue contents, advanced on every accepted request
  logic [31:0] ring_mem [QDEPTH];
  int          ring_head  = 0;
  int          ring_count = 0;

  result_t     awaited_results [$];
  int          mismatches = 0;
  int          gap_pct    = 0;
  int          stall_pct  = 0;

  fifo_queue_with_search_core #(.DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous ceiling on the whole run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 62; stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0; stall_pct = 62;
      end
      IDLE_BOTH: begin
        gap_pct = 11; stall_pct = 11;
      end
      default: begin
        gap_pct = 0; stall_pct = 0;
      end
    endcase
  endtask

  function automatic void expect_result(input status_t st, input logic [31:0] v,
                                        input int pos, input logic last);
    result_t r;
    r.status     = st;
    r.item_value = v;
    r.position   = pos[5:0];
    r.last       = last;
    awaited_results.push_back(r);
  endfunction

  // advance the shadow queue by one request and queue up what it must produce
  function automatic void queue_apply_request(input cmd_t cmd, input logic [31:0] v);
    int hits;
    int seen;
    int slot;
    hits = 0;
    seen = 0;
    case (cmd)
      CMD_ENQ: begin
        if (ring_count >= QDEPTH) begin
          expect_result(ST_FULL, '0, 0, 1'b1);
        end else begin
          ring_mem[(ring_head + ring_count) % QDEPTH] = v;
          ring_count++;
          expect_result(ST_INSERTED, '0, 0, 1'b1);
        end
      end
      CMD_DEQ: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          expect_result(ST_REMOVED, ring_mem[ring_head], 0, 1'b1);
          ring_head = (ring_head + 1) % QDEPTH;
          ring_count--;
        end
      end
      CMD_SEARCH: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          // count first so the final match can carry the last flag
          for (int i = 0; i < ring_count; i++)
            if (ring_mem[(ring_head + i) % QDEPTH] == v) hits++;
          if (hits == 0) begin
            expect_result(ST_NOMATCH, '0, 0, 1'b1);
          end else begin
            for (int i = 0; i < ring_count; i++) begin
              slot = (ring_head + i) % QDEPTH;
              if (ring_mem[slot] == v) begin
                seen++;
                expect_result(ST_MATCH, ring_mem[slot], i, seen == hits);
              end
            end
          end
        end
      end
      default: begin
        if (ring_count == 0) begin
          expect_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++)
            expect_result(ST_LISTED, ring_mem[(ring_head + i) % QDEPTH], i,
                          i == ring_count - 1);
        end
      end
    endcase
  endfunction

  // one request: optional idle cycles, then hold valid until taken.
  // valid is left high on return so back-to-back requests need no extra edge
  task automatic send_request(input cmd_t cmd, input logic [31:0] v);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    queue_apply_request(cmd, v);
  endtask

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status     = status_t'(m_tuser);
      got.item_value = m_tdata[31:0];
      got.position   = m_tdata[37:32];
      got.last       = m_tlast;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected result: status %0d value %h position %0d last %b",
                   got.status, got.item_value, got.position, got.last);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.item_value !== want.item_value ||
            got.position !== want.position || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("mismatch: expected status %0d value %h position %0d last %b, got status %0d value %h position %0d last %b",
                     want.status, want.item_value, want.position, want.last,
                     got.status, got.item_value, got.position, got.last);
        end
      end
    end
  end

  // dequeue, search and dump against an empty queue answer empty
  task automatic test_empty_queue;
    send_request(CMD_DEQ, 32'h0000_0000);
    send_request(CMD_SEARCH, 32'hFFFF_FFFF);
    send_request(CMD_DUMP, 32'h8000_0000);
  endtask

  // fill with extreme and repeated values, overflow, then dump, search, dequeue twice
  task automatic test_fill_and_walk;
    logic [31:0] fill [QDEPTH];
    fill = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
             32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0000_0001,
             32'h1234_5678, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h0F0F_F0F0,
             32'hDEAD_BEEF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFF};
    foreach (fill[i]) send_request(CMD_ENQ, fill[i]);
    send_request(CMD_ENQ, 32'h0BAD_0BAD);        // queue full
    send_request(CMD_DUMP, 32'h0000_0000);       // longest run of results
    send_request(CMD_SEARCH, 32'h7FFF_FFFF);     // several matches
    send_request(CMD_SEARCH, 32'h0000_0002);     // nothing matches
    send_request(CMD_DEQ, 32'h0000_0000);
    send_request(CMD_DEQ, 32'h0000_0000);
  endtask

  // random traffic that swings between filling and draining so both the full
  // and the empty ends are reached, with searches often aimed at stored values
  task automatic test_random_traffic(input idle_mode_t mode);
    int          pick;
    bit          filling;
    cmd_t        cmd;
    logic [31:0] v;
    set_idling(mode);
    filling = $urandom_range(1);
    for (int n = 0; n < RAND_PER_PHASE; n++) begin
      if (n % 12 == 11) filling = !filling;
      pick = $urandom_range(99);
      if (filling)
        cmd = (pick < 55) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
              (pick < 92) ? CMD_SEARCH : CMD_DUMP;
      else
        cmd = (pick < 20) ? CMD_ENQ : (pick < 65) ? CMD_DEQ :
              (pick < 88) ? CMD_SEARCH : CMD_DUMP;
      // small pool of values so repeats and multiple matches are common
      case ($urandom_range(3))
        0: v = 32'h8000_0000;
        1: v = 32'hFFFF_FFFF;
        default: v = $urandom;
      endcase
      if (cmd == CMD_SEARCH && ring_count > 0 && $urandom_range(1) == 1)
        v = ring_mem[(ring_head + $urandom_range(ring_count - 1)) % QDEPTH];
      send_request(cmd, v);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(IDLE_NONE);
    test_empty_queue();
    test_fill_and_walk();
    test_random_traffic(IDLE_NONE);
    test_random_traffic(IDLE_SENDER);
    test_random_traffic(IDLE_RECEIVER);
    test_random_traffic(IDLE_BOTH);

    s_tvalid <= 1'b0;
    set_idling(IDLE_NONE);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
